FILE: hdl/lms_pkg.sv
package lms_pkg;

   localparam int MAX_PATTERN_DEFAULT   = 8;
   localparam int POSITION_BITS_DEFAULT = 16;

   localparam int NEEDLE_BITS    = 64;
   localparam int LENGTH_BITS    = 4;
   localparam int OFFSET_BITS    = 16;
   localparam int GAP_BITS       = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [GAP_BITS-1:0] GAP_MAX = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NEEDLE_BYTES  = 2'd0,
      CSR_NEEDLE_LENGTH = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                   first_found;
      logic [OFFSET_BITS-1:0] first_start;
      logic                   last_found;
      logic [OFFSET_BITS-1:0] last_end;
      logic                   overflow;
   } result_type;

endpackage

FILE: hdl/lms_if.sv
interface lms_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lms_rsp_if;
   import lms_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   first_found;
   logic [OFFSET_BITS-1:0] first_start;
   logic                   last_found;
   logic [OFFSET_BITS-1:0] last_end;
   logic                   overflow;

   modport source (output valid, output first_found, output first_start,
                   output last_found, output last_end, output overflow, input ready);
   modport sink   (input valid, input first_found, input first_start,
                   input last_found, input last_end, input overflow, output ready);
endinterface

interface lms_csr_if;
   import lms_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/last_match_substring_search_unit.sv
// A byte is held in the input register and scanned from there; a final byte's
// result is then held in the result register and offered from it.
// Throughput: one haystack byte per cycle, set by the single window compare and
// position update per clock; a final byte waits while a result is still held.
// Reset (synchronous, active high) clears the needle registers, the window,
// all match tracking and the valid bits of both channel registers.
module last_match_substring_search_unit #(
   parameter int MAX_PATTERN   = lms_pkg::MAX_PATTERN_DEFAULT,
   parameter int POSITION_BITS = lms_pkg::POSITION_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lms_req_if.sink   req_chan,
   lms_rsp_if.source rsp_chan,
   lms_csr_if.sink   csr_chan
);
   import lms_pkg::*;

   // Configuration registers.
   logic [NEEDLE_BITS-1:0] needle_ff;
   logic [LENGTH_BITS-1:0] length_ff;
   logic [LENGTH_BITS-1:0] pattern_len;

   // Input register: one byte waiting to be scanned.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type result;

   logic can_load;
   logic step;
   logic match;

   // Lengths beyond the window are treated as a full window.
   assign pattern_len = (length_ff > LENGTH_BITS'(MAX_PATTERN)) ?
                        LENGTH_BITS'(MAX_PATTERN) : length_ff;

   // Configuration writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff <= '0;
         length_ff <= '0;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == CSR_NEEDLE_BYTES) begin
            needle_ff <= csr_chan.data;
         end else if (csr_chan.index == CSR_NEEDLE_LENGTH) begin
            length_ff <= csr_chan.data[LENGTH_BITS-1:0];
         end
      end
   end

   // A byte that is not final can always be scanned. A final byte needs the
   // result register to be free, or to be emptied by a transfer this cycle.
   assign can_load       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && (!in_last_ff || can_load);
   assign req_chan.ready = !in_valid_ff || step;
   assign in_valid_in    = req_chan.ready ? req_chan.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   lms_window #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .clear       (in_last_ff),
      .data_byte   (in_byte_ff),
      .needle_bytes(needle_ff),
      .pattern_len (pattern_len),
      .match       (match)
   );

   lms_track #(
      .POSITION_BITS(POSITION_BITS)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .final_byte (in_last_ff),
      .match      (match),
      .pattern_len(pattern_len),
      .result     (result)
   );

   // The result register loads when a final byte is scanned and drops its
   // valid after the downstream transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.first_found = rsp_data_ff.first_found;
   assign rsp_chan.first_start = rsp_data_ff.first_start;
   assign rsp_chan.last_found  = rsp_data_ff.last_found;
   assign rsp_chan.last_end    = rsp_data_ff.last_end;
   assign rsp_chan.overflow    = rsp_data_ff.overflow;

endmodule

FILE: hdl/lms_window.sv
module lms_window #(
   parameter int MAX_PATTERN = lms_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           clear,
   input  logic [7:0]                     data_byte,
   input  logic [lms_pkg::NEEDLE_BITS-1:0] needle_bytes,
   input  logic [lms_pkg::LENGTH_BITS-1:0] pattern_len,
   output logic                           match
);
   import lms_pkg::*;

   localparam int WINDOW_BITS = 8 * MAX_PATTERN;

   logic [WINDOW_BITS-1:0] window_ff;
   logic [WINDOW_BITS-1:0] window_in;
   logic [WINDOW_BITS+7:0] shifted;
   logic [MAX_PATTERN:0]   len_hit;

   // The newest byte sits in the low byte of the window.
   assign shifted   = {window_ff, data_byte};
   assign window_in = shifted[WINDOW_BITS-1:0];

   // One comparator set per candidate length: pattern byte j against the byte
   // that arrived (length-1-j) steps ago.
   always_comb begin
      len_hit = '0;
      match   = 1'b0;
      for (int len = 1; len <= MAX_PATTERN; len++) begin
         len_hit[len] = 1'b1;
         for (int j = 0; j < len; j++) begin
            if (window_in[8*(len-1-j) +: 8] != needle_bytes[8*j +: 8]) begin
               len_hit[len] = 1'b0;
            end
         end
      end
      for (int len = 1; len <= MAX_PATTERN; len++) begin
         if (pattern_len == LENGTH_BITS'(len)) begin
            match = len_hit[len];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (step) begin
         window_ff <= clear ? '0 : window_in;
      end
   end

endmodule

FILE: hdl/lms_track.sv
module lms_track #(
   parameter int POSITION_BITS = lms_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            final_byte,
   input  logic                            match,
   input  logic [lms_pkg::LENGTH_BITS-1:0] pattern_len,
   output lms_pkg::result_type             result
);
   import lms_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [GAP_BITS-1:0]      gap_ff, gap_in, gap_next;
   logic                     first_seen_ff, first_seen_in;
   logic [POSITION_BITS-1:0] first_off_ff, first_off_in;
   logic                     last_seen_ff, last_seen_in;
   logic [POSITION_BITS-1:0] last_off_ff, last_off_in;
   logic                     sat_ff, sat_in;

   logic                     ovf;
   logic                     hit;
   logic [POSITION_BITS-1:0] len_pos;
   logic [POSITION_BITS-1:0] end_pos;
   logic [POSITION_BITS-1:0] start_pos;
   logic [31:0]              first_wide;
   logic [31:0]              last_wide;

   always_comb begin
      ovf       = (pos_ff == POS_MAX);
      len_pos   = POSITION_BITS'(pattern_len);
      gap_next  = (gap_ff != GAP_MAX) ? gap_ff + 1'b1 : gap_ff;
      hit       = match && (pattern_len != '0) && (gap_next >= pattern_len);
      end_pos   = ovf ? POS_MAX : pos_ff + 1'b1;
      if (ovf) begin
         start_pos = POS_MAX;
      end else if (end_pos >= len_pos) begin
         start_pos = end_pos - len_pos;
      end else begin
         start_pos = '0;
      end

      pos_in        = ovf ? pos_ff : pos_ff + 1'b1;
      sat_in        = sat_ff | ovf;
      gap_in        = hit ? '0 : gap_next;
      first_seen_in = first_seen_ff | hit;
      first_off_in  = (hit && !first_seen_ff) ? start_pos : first_off_ff;
      last_seen_in  = last_seen_ff | hit;
      last_off_in   = hit ? end_pos : last_off_ff;

      first_wide = 32'(first_off_in);
      last_wide  = 32'(last_off_in);

      if (pattern_len == '0) begin
         result.first_found = 1'b1;
         result.first_start = '0;
         result.last_found  = 1'b0;
         result.last_end    = '0;
      end else begin
         result.first_found = first_seen_in;
         result.first_start = first_seen_in ? first_wide[OFFSET_BITS-1:0] : '0;
         result.last_found  = last_seen_in;
         result.last_end    = last_seen_in ? last_wide[OFFSET_BITS-1:0] : '0;
      end
      result.overflow = sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && final_byte)) begin
         pos_ff        <= '0;
         gap_ff        <= '0;
         first_seen_ff <= 1'b0;
         first_off_ff  <= '0;
         last_seen_ff  <= 1'b0;
         last_off_ff   <= '0;
         sat_ff        <= 1'b0;
      end else if (step) begin
         pos_ff        <= pos_in;
         gap_ff        <= gap_in;
         first_seen_ff <= first_seen_in;
         first_off_ff  <= first_off_in;
         last_seen_ff  <= last_seen_in;
         last_off_ff   <= last_off_in;
         sat_ff        <= sat_in;
      end
   end

endmodule

FILE: hdl/lms_checker.sv
module lms_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_first_found,
   input logic [lms_pkg::OFFSET_BITS-1:0] rsp_first_start,
   input logic                            rsp_last_found,
   input logic [lms_pkg::OFFSET_BITS-1:0] rsp_last_end,
   input logic                            rsp_overflow
);
   import lms_pkg::*;

   // No result survives a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A result offered but not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // A counted last match implies a first match that starts no later than it ends.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_found |-> rsp_first_found && (rsp_first_start <= rsp_last_end))
      else $error("last match without consistent first match");

   // Without saturation a match ends at least one byte into the haystack.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_found && !rsp_overflow |-> rsp_last_end != '0)
      else $error("last match ends at offset zero");

endmodule

bind last_match_substring_search_unit lms_checker u_lms_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_first_found(rsp_chan.first_found),
   .rsp_first_start(rsp_chan.first_start),
   .rsp_last_found (rsp_chan.last_found),
   .rsp_last_end   (rsp_chan.last_end),
   .rsp_overflow   (rsp_chan.overflow)
);
